[hw/rtl/sbda_pkg.sv]
package sbda_pkg;

	localparam int WORD_BITS = 64;
	localparam int DIGITS = 19;
	localparam int DIGIT_IDX_BITS = $clog2(DIGITS);
	localparam int STEP_BITS = 8;

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO = 8'd48;

	// Work item moving down the conversion pipeline: the BCD accumulator and the
	// binary bits still to be shifted in, most significant bit first.
	typedef struct packed {
		logic neg;
		logic [DIGITS*4-1:0] bcd;
		logic [WORD_BITS-1:0] bin;
	} sbda_work_t;

endpackage

[hw/rtl/sbda_value_if.sv]
interface sbda_value_if;
	logic valid;
	logic ready;
	logic signed [63:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

[hw/rtl/sbda_char_if.sv]
interface sbda_char_if;
	logic valid;
	logic ready;
	logic [7:0] character;
	logic last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

[hw/rtl/sbda_dabble.sv]
module sbda_dabble import sbda_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sbda_work_t in_work,
	output logic out_valid,
	input logic out_ready,
	output sbda_work_t out_work
);

	logic valid_s1;
	sbda_work_t work_s1;
	sbda_work_t next_work;

	// Shift-add-3 over STEP_BITS bits.
	always_comb begin
		next_work = in_work;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (next_work.bcd[d*4 +: 4] >= 4'd5) begin
					next_work.bcd[d*4 +: 4] = next_work.bcd[d*4 +: 4] + 4'd3;
				end
			end
			next_work.bcd = {next_work.bcd[DIGITS*4-2:0], next_work.bin[WORD_BITS-1]};
			next_work.bin = {next_work.bin[WORD_BITS-2:0], 1'b0};
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= next_work;
		end
	end

	assign out_valid = valid_s1;
	assign out_work = work_s1;

endmodule

[hw/rtl/sbda_serializer.sv]
module sbda_serializer import sbda_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sbda_work_t in_work,
	sbda_char_if.source text
);

	logic busy_q;
	logic neg_q;
	logic [DIGIT_IDX_BITS-1:0] ptr_q;
	logic [DIGITS*4-1:0] bcd_q;
	logic [DIGIT_IDX_BITS-1:0] msd;
	logic [3:0] digit;
	logic take;
	logic final_char;

	// Highest nonzero digit; zero value leaves digit 0.
	always_comb begin
		msd = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (in_work.bcd[d*4 +: 4] != 4'd0) begin
				msd = DIGIT_IDX_BITS'(d);
			end
		end
	end

	assign digit = bcd_q[ptr_q*4 +: 4];
	assign final_char = !neg_q && (ptr_q == '0);
	assign take = text.valid && text.ready;
	assign in_ready = !busy_q || (take && final_char);

	assign text.valid = busy_q;
	assign text.character = neg_q ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digit});
	assign text.last = final_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_ready) begin
			busy_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			neg_q <= in_work.neg;
			ptr_q <= msd;
			bcd_q <= in_work.bcd;
		end else if (take) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else if (ptr_q != '0) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/signed_binary_to_decimal_ascii.sv]
// Signed binary to decimal ASCII converter.
// Input channel value_in carries one signed two's complement integer per
// request; only the low VALUE_BITS bits count, the top one being the sign.
// Output channel text_out carries one ASCII character per request: a '-'
// for negative values, then the decimal digits most significant first with
// leading zeros dropped (zero gives a single '0'); last marks the final one.
// Pipeline: one sign/magnitude stage, then ceil(VALUE_BITS/8) double-dabble
// stages of eight shift-add-3 steps each, then a character serializer.
// The serializer emits one character per cycle while text_out does not
// stall; a value has 1 to 20 characters. The pipeline stages ahead of it
// keep accepting a new value every cycle until they fill.
// Reset clears every valid bit; no request is in flight afterwards.
// When text_out stalls, the serializer holds its character and the stall
// backs up stage by stage to value_in.ready; nothing is dropped or repeated.
module signed_binary_to_decimal_ascii import sbda_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input logic clk,
	input logic arst_n,
	sbda_value_if.sink value_in,
	sbda_char_if.source text_out
);

	localparam int STAGES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD = WORD_BITS - STAGES * STEP_BITS;

	logic [WORD_BITS-1:0] raw;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] mag;
	logic neg;
	sbda_work_t front_work;

	logic valid_s1;
	sbda_work_t work_s1;

	logic [STAGES:0] stg_valid;
	logic [STAGES:0] stg_ready;
	sbda_work_t stg_work [STAGES+1];

	// Keep the low VALUE_BITS bits, then take the magnitude.
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			mask[i] = (i < VALUE_BITS);
			raw[i] = (i < VALUE_BITS) ? value_in.value[i] : 1'b0;
		end
	end

	assign neg = raw[VALUE_BITS-1];
	assign mag = neg ? ((~raw + 64'd1) & mask) : raw;

	// Left-align so the dabble stages shift out exactly STAGES*8 bits.
	always_comb begin
		front_work.neg = neg;
		front_work.bcd = '0;
		front_work.bin = mag << PAD;
	end

	assign value_in.ready = !valid_s1 || stg_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (value_in.ready) begin
			valid_s1 <= value_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (value_in.ready && value_in.valid) begin
			work_s1 <= front_work;
		end
	end

	assign stg_valid[0] = valid_s1;
	assign stg_work[0] = work_s1;

	// Double-dabble chain; each stage holds its own valid bit.
	for (genvar g = 0; g < STAGES; g++) begin : g_dabble
		sbda_dabble u_dabble (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(stg_valid[g]),
			.in_ready(stg_ready[g]),
			.in_work(stg_work[g]),
			.out_valid(stg_valid[g+1]),
			.out_ready(stg_ready[g+1]),
			.out_work(stg_work[g+1])
		);
	end

	sbda_serializer u_serializer (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(stg_valid[STAGES]),
		.in_ready(stg_ready[STAGES]),
		.in_work(stg_work[STAGES]),
		.text(text_out)
	);

`ifndef SYNTHESIS
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid |-> (text_out.character == CHAR_MINUS ||
			(text_out.character >= CHAR_ZERO && text_out.character <= 8'd57)))
		else $error("character out of range");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text_out.valid && text_out.character == CHAR_MINUS) |-> !text_out.last)
		else $error("minus sign marked last");

	a_minus_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(text_out.valid && text_out.ready && text_out.character == CHAR_MINUS)
		|=> (text_out.valid && text_out.character != CHAR_MINUS))
		else $error("minus sign not followed by digit");
`endif

endmodule
